[hdl/clkft_pkg.sv]
// Package for the clock frame table: widths, request and result codes,
// and the command and status records between controller and datapath.
// Used by every other file of the block.
`default_nettype none

package clkft_pkg;

   localparam int FRAMES  = 32;
   localparam int SLOT_W  = 5;
   localparam int SCAN_W  = 6;
   localparam int PAGE_W  = 20;
   localparam int OWNER_W = 8;
   localparam int FILE_W  = 8;
   localparam int KIND_W  = 3;
   localparam int STAT_W  = 3;
   localparam int LIMIT_W = 6;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic [KIND_W-1:0] KIND_ALLOC  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ACCESS = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FREE   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_UNMAP  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd4;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd5;

   localparam logic [STAT_W-1:0] STAT_ALLOC   = 3'd0;
   localparam logic [STAT_W-1:0] STAT_EVICT   = 3'd1;
   localparam logic [STAT_W-1:0] STAT_REMOVED = 3'd2;
   localparam logic [STAT_W-1:0] STAT_HIT     = 3'd3;
   localparam logic [STAT_W-1:0] STAT_MISS    = 3'd4;

   localparam logic [CSR_AW-1:0]  CSR_FRAME_LIMIT = 3'd0;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 6'd32;

   typedef enum logic [2:0] {
      SCAN_HOLD,
      SCAN_ZERO,
      SCAN_HAND,
      SCAN_FRAME,
      SCAN_INC
   } scan_op_type;

   typedef enum logic [2:0] {
      OUT_NONE,
      OUT_ALLOC,
      OUT_EVICT,
      OUT_MISS,
      OUT_MISS_FI,
      OUT_FREED,
      OUT_HIT,
      OUT_PEND_MORE
   } out_op_type;

   typedef struct packed {
      logic        req_load;
      scan_op_type scan_op;
      logic        fill;
      logic        acc_clear;
      logic        acc_set;
      logic        slot_clear;
      logic        hand_set;
      logic        pend_load;
      logic        pend_last;
      out_op_type  out_op;
   } dp_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              cur_valid;
      logic              cur_acc;
      logic              cur_match;
      logic              at_limit;
      logic              scan_end;
      logic              any_valid;
      logic              o_free;
      logic              pend_valid;
   } dp_stat_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [PAGE_W-1:0]  page_number;
      logic [OWNER_W-1:0] owner_id;
      logic [SLOT_W-1:0]  frame_index;
      logic [FILE_W-1:0]  file_id;
      logic               mmap_flag;
      logic               zero_fill;
   } req_item_type;

endpackage

`default_nettype wire

[hdl/clkft_chan_if.sv]
// Channel interfaces of the clock frame table: request and result streams.
// Depends on clkft_pkg for field widths.
`default_nettype none

interface clkft_req_if import clkft_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [PAGE_W-1:0]  page_number;
   logic [OWNER_W-1:0] owner_id;
   logic [SLOT_W-1:0]  frame_index;
   logic [FILE_W-1:0]  file_id;
   logic               mmap_flag;
   logic               zero_fill;

   modport source (output valid, kind, page_number, owner_id, frame_index, file_id,
                   mmap_flag, zero_fill, input ready);
   modport sink   (input valid, kind, page_number, owner_id, frame_index, file_id,
                   mmap_flag, zero_fill, output ready);
endinterface

interface clkft_rsp_if import clkft_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [STAT_W-1:0]  status;
   logic [SLOT_W-1:0]  out_frame;
   logic [PAGE_W-1:0]  out_page;
   logic [OWNER_W-1:0] out_owner;
   logic               swap_out;
   logic               write_back;
   logic [FILE_W-1:0]  out_file;
   logic               clear_frame;
   logic               last;

   modport source (output valid, status, out_frame, out_page, out_owner, swap_out,
                   write_back, out_file, clear_frame, last, input ready);
   modport sink   (input valid, status, out_frame, out_page, out_owner, swap_out,
                   write_back, out_file, clear_frame, last, output ready);
endinterface

`default_nettype wire

[hdl/clock_frame_table_core.sv]
// Clock frame table top level: 32 frame slots with second-chance eviction.
// Access, free and lookup requests use the one slot that they name, unknown kinds miss;
// allocate takes the first free slot below the frame limit, else, if any slot is valid,
// sweeps the clock from the hand and evicts, and misses otherwise; unmap and remove walk
// all 32 slots. One request at a time; the clock sweep and the slot walk step one slot
// per cycle, but a walk holds on a match while an earlier match waits to move out.
// Synchronous reset empties the table, sets the hand to 0 and frame_limit to 32.
`default_nettype none

module clock_frame_table_core import clkft_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   clkft_req_if.sink              req_ch,
   clkft_rsp_if.source            rsp_ch,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0]      csr_prdata,
   output logic                   csr_pready
);

   logic [LIMIT_W-1:0] frame_limit_ff;
   dp_cmd_type         cmd;
   dp_stat_type        stat;
   req_item_type       req_item;
   logic               ready;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_FRAME_LIMIT) ?
                       CSR_DW'(frame_limit_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_limit_ff <= LIMIT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_FRAME_LIMIT) begin
         frame_limit_ff <= csr_pwdata[LIMIT_W-1:0];
      end
   end

   assign req_ch.ready = ready;

   always_comb begin
      req_item.kind        = req_ch.kind;
      req_item.page_number = req_ch.page_number;
      req_item.owner_id    = req_ch.owner_id;
      req_item.frame_index = req_ch.frame_index;
      req_item.file_id     = req_ch.file_id;
      req_item.mmap_flag   = req_ch.mmap_flag;
      req_item.zero_fill   = req_ch.zero_fill;
   end

   clkft_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_ch.valid && ready),
      .stat       (stat),
      .req_ready  (ready),
      .cmd        (cmd)
   );

   clkft_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_item    (req_item),
      .frame_limit (frame_limit_ff),
      .cmd         (cmd),
      .stat        (stat),
      .rsp         (rsp_ch)
   );

endmodule

`default_nettype wire

[hdl/clkft_dpath.sv]
// Datapath of the clock frame table: slot storage, clock hand, scan pointer,
// pending walk result and the result register. Depends on clkft_pkg and clkft_chan_if.
`default_nettype none

module clkft_dpath import clkft_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire req_item_type       req_item,
   input  wire logic [LIMIT_W-1:0] frame_limit,
   input  wire dp_cmd_type         cmd,
   output dp_stat_type             stat,
   clkft_rsp_if.source             rsp
);

   // latched request
   req_item_type req_ff;

   logic [SCAN_W-1:0] scan_ff, scan_in;
   logic [SLOT_W-1:0] hand_ff;
   logic [FRAMES-1:0] valid_ff;
   logic [FRAMES-1:0] acc_ff;
   logic [FRAMES-1:0] mapped_ff;
   logic [PAGE_W-1:0]  page_ff  [FRAMES];
   logic [OWNER_W-1:0] owner_ff [FRAMES];
   logic [FILE_W-1:0]  file_ff  [FRAMES];

   logic               pend_valid_ff;
   logic [SLOT_W-1:0]  pend_frame_ff;
   logic [PAGE_W-1:0]  pend_page_ff;
   logic [OWNER_W-1:0] pend_owner_ff;
   logic               pend_mapped_ff;
   logic [FILE_W-1:0]  pend_file_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic [SLOT_W-1:0]  frame_ff, frame_in;
   logic [PAGE_W-1:0]  opage_ff, opage_in;
   logic [OWNER_W-1:0] oowner_ff, oowner_in;
   logic               swap_ff, swap_in;
   logic               wb_ff, wb_in;
   logic [FILE_W-1:0]  ofile_ff, ofile_in;
   logic               clear_ff, clear_in;
   logic               last_ff, last_in;

   logic [SLOT_W-1:0]  cur;
   logic [LIMIT_W-1:0] lim;
   logic               o_free;

   assign cur    = scan_ff[SLOT_W-1:0];
   assign lim    = (frame_limit > LIMIT_W'(FRAMES)) ? LIMIT_W'(FRAMES) : frame_limit;
   assign o_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      stat.kind       = req_ff.kind;
      stat.cur_valid  = valid_ff[cur];
      stat.cur_acc    = acc_ff[cur];
      if (req_ff.kind == KIND_UNMAP) begin
         stat.cur_match = mapped_ff[cur] && (file_ff[cur] == req_ff.file_id);
      end else begin
         stat.cur_match = owner_ff[cur] == req_ff.owner_id;
      end
      stat.at_limit   = scan_ff >= SCAN_W'(lim);
      stat.scan_end   = scan_ff == SCAN_W'(FRAMES);
      stat.any_valid  = |valid_ff;
      stat.o_free     = o_free;
      stat.pend_valid = pend_valid_ff;
   end

   always_comb begin
      case (cmd.scan_op)
         SCAN_ZERO:  scan_in = '0;
         SCAN_HAND:  scan_in = SCAN_W'(hand_ff);
         SCAN_FRAME: scan_in = SCAN_W'(req_ff.frame_index);
         SCAN_INC:   scan_in = scan_ff + SCAN_W'(1);
         default:    scan_in = scan_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff       <= '0;
         hand_ff       <= '0;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.hand_set) begin
            hand_ff <= cur + SLOT_W'(1);
         end
         if (cmd.fill) begin
            valid_ff[cur] <= 1'b1;
         end else if (cmd.slot_clear) begin
            valid_ff[cur] <= 1'b0;
         end
         if (cmd.pend_load) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.pend_last) begin
            pend_valid_ff <= 1'b0;
         end
      end
   end

   // payload storage, no reset
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         req_ff <= req_item;
      end
      if (cmd.fill) begin
         page_ff[cur]   <= req_ff.page_number;
         owner_ff[cur]  <= req_ff.owner_id;
         file_ff[cur]   <= req_ff.file_id;
         mapped_ff[cur] <= req_ff.mmap_flag;
         acc_ff[cur]    <= 1'b0;
      end else if (cmd.acc_clear) begin
         acc_ff[cur] <= 1'b0;
      end else if (cmd.acc_set) begin
         acc_ff[cur] <= 1'b1;
      end
      if (cmd.pend_load) begin
         pend_frame_ff  <= cur;
         pend_page_ff   <= page_ff[cur];
         pend_owner_ff  <= owner_ff[cur];
         pend_mapped_ff <= mapped_ff[cur];
         pend_file_ff   <= mapped_ff[cur] ? file_ff[cur] : '0;
      end
      status_ff <= status_in;
      frame_ff  <= frame_in;
      opage_ff  <= opage_in;
      oowner_ff <= oowner_in;
      swap_ff   <= swap_in;
      wb_ff     <= wb_in;
      ofile_ff  <= ofile_in;
      clear_ff  <= clear_in;
      last_ff   <= last_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      status_in    = status_ff;
      frame_in     = frame_ff;
      opage_in     = opage_ff;
      oowner_in    = oowner_ff;
      swap_in      = swap_ff;
      wb_in        = wb_ff;
      ofile_in     = ofile_ff;
      clear_in     = clear_ff;
      last_in      = last_ff;
      if (cmd.out_op != OUT_NONE || cmd.pend_last) begin
         rsp_valid_in = 1'b1;
         status_in    = STAT_MISS;
         frame_in     = '0;
         opage_in     = '0;
         oowner_in    = '0;
         swap_in      = 1'b0;
         wb_in        = 1'b0;
         ofile_in     = '0;
         clear_in     = 1'b0;
         last_in      = 1'b1;
      end
      if (cmd.pend_last) begin
         status_in = STAT_REMOVED;
         frame_in  = pend_frame_ff;
         opage_in  = pend_page_ff;
         oowner_in = pend_owner_ff;
         wb_in     = pend_mapped_ff;
         ofile_in  = pend_file_ff;
      end
      case (cmd.out_op)
         OUT_ALLOC: begin
            status_in = STAT_ALLOC;
            frame_in  = cur;
            clear_in  = req_ff.zero_fill;
         end
         OUT_EVICT: begin
            status_in = STAT_EVICT;
            frame_in  = cur;
            opage_in  = page_ff[cur];
            oowner_in = owner_ff[cur];
            swap_in   = 1'b1;
            wb_in     = mapped_ff[cur];
            ofile_in  = mapped_ff[cur] ? file_ff[cur] : '0;
            clear_in  = req_ff.zero_fill;
         end
         OUT_MISS_FI: begin
            frame_in = req_ff.frame_index;
         end
         OUT_FREED, OUT_HIT: begin
            status_in = (cmd.out_op == OUT_FREED) ? STAT_REMOVED : STAT_HIT;
            frame_in  = cur;
            opage_in  = page_ff[cur];
            oowner_in = owner_ff[cur];
         end
         OUT_PEND_MORE: begin
            status_in = STAT_REMOVED;
            frame_in  = pend_frame_ff;
            opage_in  = pend_page_ff;
            oowner_in = pend_owner_ff;
            wb_in     = pend_mapped_ff;
            ofile_in  = pend_file_ff;
            last_in   = 1'b0;
         end
         default: begin
         end
      endcase
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.out_frame   = frame_ff;
   assign rsp.out_page    = opage_ff;
   assign rsp.out_owner   = oowner_ff;
   assign rsp.swap_out    = swap_ff;
   assign rsp.write_back  = wb_ff;
   assign rsp.out_file    = ofile_ff;
   assign rsp.clear_frame = clear_ff;
   assign rsp.last        = last_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_op != OUT_NONE || cmd.pend_last) |-> o_free)
      else $error("result register overwritten");

   a_fill_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.fill |-> (!valid_ff[cur] || cmd.out_op == OUT_EVICT))
      else $error("fill over a live slot without eviction");

   a_pend_flush: assert property (@(posedge clock) disable iff (reset)
      (cmd.pend_load && pend_valid_ff) |-> cmd.out_op == OUT_PEND_MORE)
      else $error("pending walk result dropped");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (valid_ff == '0 && !rsp_valid_ff))
      else $error("table not empty after reset");

endmodule

`default_nettype wire

[hdl/clkft_ctrl.sv]
// Controller of the clock frame table: sequences free scan, clock sweep,
// walks and single-slot requests. Depends on clkft_pkg.
`default_nettype none

module clkft_ctrl import clkft_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_accept,
   input  wire dp_stat_type stat,
   output logic             req_ready,
   output dp_cmd_type       cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_FREE_SCAN,
      ST_SWEEP,
      ST_SINGLE,
      ST_WALK,
      ST_WALK_END,
      ST_MISS
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   assign req_ready = ready_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      ready_in = ready_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd.req_load = 1'b1;
               state_in     = ST_DISPATCH;
               ready_in     = 1'b0;
            end
         end
         ST_DISPATCH: begin
            case (stat.kind)
               KIND_ALLOC: begin
                  cmd.scan_op = SCAN_ZERO;
                  state_in    = ST_FREE_SCAN;
               end
               KIND_ACCESS, KIND_FREE, KIND_LOOKUP: begin
                  cmd.scan_op = SCAN_FRAME;
                  state_in    = ST_SINGLE;
               end
               KIND_UNMAP, KIND_REMOVE: begin
                  cmd.scan_op = SCAN_ZERO;
                  state_in    = ST_WALK;
               end
               default: state_in = ST_MISS;
            endcase
         end
         ST_FREE_SCAN: begin
            if (stat.at_limit) begin
               if (stat.any_valid) begin
                  cmd.scan_op = SCAN_HAND;
                  state_in    = ST_SWEEP;
               end else begin
                  state_in = ST_MISS;
               end
            end else if (!stat.cur_valid) begin
               if (stat.o_free) begin
                  cmd.fill   = 1'b1;
                  cmd.out_op = OUT_ALLOC;
                  state_in   = ST_IDLE;
                  ready_in   = 1'b1;
               end
            end else begin
               cmd.scan_op = SCAN_INC;
            end
         end
         ST_SWEEP: begin
            // second chance: clear a set accessed bit and pass over the slot
            if (stat.cur_valid && !stat.cur_acc) begin
               if (stat.o_free) begin
                  cmd.out_op   = OUT_EVICT;
                  cmd.fill     = 1'b1;
                  cmd.hand_set = 1'b1;
                  state_in     = ST_IDLE;
                  ready_in     = 1'b1;
               end
            end else begin
               cmd.acc_clear = stat.cur_valid;
               cmd.scan_op   = SCAN_INC;
            end
         end
         ST_SINGLE: begin
            if (stat.o_free) begin
               state_in = ST_IDLE;
               ready_in = 1'b1;
               if (!stat.cur_valid) begin
                  cmd.out_op = OUT_MISS_FI;
               end else if (stat.kind == KIND_FREE) begin
                  cmd.out_op     = OUT_FREED;
                  cmd.slot_clear = 1'b1;
               end else begin
                  cmd.out_op  = OUT_HIT;
                  cmd.acc_set = stat.kind == KIND_ACCESS;
               end
            end
         end
         ST_WALK: begin
            if (stat.scan_end) begin
               state_in = ST_WALK_END;
            end else if (stat.cur_valid && stat.cur_match) begin
               // hold the match until the previous one can move out
               if (!stat.pend_valid || stat.o_free) begin
                  if (stat.pend_valid) begin
                     cmd.out_op = OUT_PEND_MORE;
                  end
                  cmd.pend_load  = 1'b1;
                  cmd.slot_clear = 1'b1;
                  cmd.scan_op    = SCAN_INC;
               end
            end else begin
               cmd.scan_op = SCAN_INC;
            end
         end
         ST_WALK_END: begin
            if (stat.o_free) begin
               if (stat.pend_valid) begin
                  cmd.pend_last = 1'b1;
               end else begin
                  cmd.out_op = OUT_MISS;
               end
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end
         end
         ST_MISS: begin
            if (stat.o_free) begin
               cmd.out_op = OUT_MISS;
               state_in   = ST_IDLE;
               ready_in   = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

endmodule

`default_nettype wire

[test/clock_frame_table_core_tb.sv]
// Testbench for clock_frame_table_core: directed table, then random request phases
// under several frame limits, checked against typed expectations or a table predictor.
// Depends on clkft_pkg and the clkft_req_if / clkft_rsp_if channel interfaces.
`timescale 1ns / 1ps

module clock_frame_table_core_tb;
   import clkft_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 80;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [SLOT_W-1:0]  frame;
      logic [PAGE_W-1:0]  page;
      logic [OWNER_W-1:0] owner;
      logic               swap;
      logic               wback;
      logic [FILE_W-1:0]  file;
      logic               clr;
      logic               last;
   } frame_rsp_type;

   typedef struct packed {
      logic          is_cfg;
      logic [5:0]    limit_val;
      req_item_type  item;
      logic          typed;
      frame_rsp_type want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   clkft_req_if req_bus ();
   clkft_rsp_if rsp_bus ();

   clock_frame_table_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus.sink),
      .rsp_ch      (rsp_bus.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predicted frame table
   bit                 tbl_valid [FRAMES];
   logic [PAGE_W-1:0]  tbl_page  [FRAMES];
   logic [OWNER_W-1:0] tbl_owner [FRAMES];
   bit                 tbl_acc   [FRAMES];
   bit                 tbl_mapped[FRAMES];
   logic [FILE_W-1:0]  tbl_file  [FRAMES];
   int                 hand;
   int                 frame_limit;

   frame_rsp_type pending_rsp[$];
   int err_count;
   int req_count;
   int rsp_count;
   int evict_count;
   int removed_count;
   int cycle_count;
   bit stim_done;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic report(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      err_count++;
   endtask

   function automatic frame_rsp_type rsp_of(input logic [STAT_W-1:0] st, input int fr,
                                            input logic [PAGE_W-1:0] pg,
                                            input logic [OWNER_W-1:0] ow, input bit sw,
                                            input bit wb, input logic [FILE_W-1:0] fl,
                                            input bit cl);
      frame_rsp_type r;
      r.status = st;
      r.frame  = fr[SLOT_W-1:0];
      r.page   = pg;
      r.owner  = ow;
      r.swap   = sw;
      r.wback  = wb;
      r.file   = fl;
      r.clr    = cl;
      r.last   = 1'b1;
      return r;
   endfunction

   function automatic req_item_type req_of(input logic [KIND_W-1:0] k,
                                           input logic [PAGE_W-1:0] pg,
                                           input logic [OWNER_W-1:0] ow, input int fi,
                                           input logic [FILE_W-1:0] fl, input bit mm,
                                           input bit zf);
      req_item_type r;
      r.kind        = k;
      r.page_number = pg;
      r.owner_id    = ow;
      r.frame_index = fi[SLOT_W-1:0];
      r.file_id     = fl;
      r.mmap_flag   = mm;
      r.zero_fill   = zf;
      return r;
   endfunction

   task automatic fill_slot(input int s, input req_item_type r);
      tbl_valid[s]  = 1'b1;
      tbl_page[s]   = r.page_number;
      tbl_owner[s]  = r.owner_id;
      tbl_acc[s]    = 1'b0;
      tbl_mapped[s] = r.mmap_flag;
      tbl_file[s]   = r.file_id;
   endtask

   // Advance the predicted table by one request and queue the results it causes.
   task automatic predict_frame_rsp(input req_item_type r);
      frame_rsp_type e;
      int lim, s, fi, n;
      bit found, any;
      e = rsp_of(STAT_MISS, 0, '0, '0, 0, 0, '0, 0);
      fi = r.frame_index;
      case (r.kind)
         KIND_ALLOC: begin
            lim = (frame_limit > FRAMES) ? FRAMES : frame_limit;
            found = 0;
            for (s = 0; s < lim && !found; s++) begin
               if (!tbl_valid[s]) begin
                  fill_slot(s, r);
                  e = rsp_of(STAT_ALLOC, s, '0, '0, 0, 0, '0, r.zero_fill);
                  found = 1;
               end
            end
            any = 0;
            for (s = 0; s < FRAMES; s++) any |= tbl_valid[s];
            if (!found && any) begin
               s = hand;
               // second chance: clear set accessed bits until a clear one turns up
               while (!(tbl_valid[s] && !tbl_acc[s])) begin
                  if (tbl_valid[s]) tbl_acc[s] = 1'b0;
                  s = (s + 1) % FRAMES;
               end
               hand = (s + 1) % FRAMES;
               e = rsp_of(STAT_EVICT, s, tbl_page[s], tbl_owner[s], 1, tbl_mapped[s],
                          tbl_mapped[s] ? tbl_file[s] : '0, r.zero_fill);
               fill_slot(s, r);
            end
            pending_rsp.push_back(e);
         end
         KIND_ACCESS, KIND_FREE, KIND_LOOKUP: begin
            if (!tbl_valid[fi]) begin
               e.frame = fi[SLOT_W-1:0];
            end else if (r.kind == KIND_FREE) begin
               e = rsp_of(STAT_REMOVED, fi, tbl_page[fi], tbl_owner[fi], 0, 0, '0, 0);
               tbl_valid[fi] = 1'b0;
            end else begin
               if (r.kind == KIND_ACCESS) tbl_acc[fi] = 1'b1;
               e = rsp_of(STAT_HIT, fi, tbl_page[fi], tbl_owner[fi], 0, 0, '0, 0);
            end
            pending_rsp.push_back(e);
         end
         KIND_UNMAP, KIND_REMOVE: begin
            n = 0;
            for (s = 0; s < FRAMES; s++) begin
               if (tbl_valid[s] && ((r.kind == KIND_UNMAP) ?
                     (tbl_mapped[s] && tbl_file[s] == r.file_id) :
                     (tbl_owner[s] == r.owner_id))) begin
                  e = rsp_of(STAT_REMOVED, s, tbl_page[s], tbl_owner[s], 0, tbl_mapped[s],
                             tbl_mapped[s] ? tbl_file[s] : '0, 0);
                  e.last = 1'b0;
                  pending_rsp.push_back(e);
                  tbl_valid[s] = 1'b0;
                  n++;
               end
            end
            if (n == 0) begin
               pending_rsp.push_back(rsp_of(STAT_MISS, 0, '0, '0, 0, 0, '0, 0));
            end else begin
               e = pending_rsp.pop_back();
               e.last = 1'b1;
               pending_rsp.push_back(e);
            end
         end
         default: pending_rsp.push_back(e);
      endcase
   endtask

   task automatic send_request(input req_item_type r, input int gap, input bit typed,
                               input frame_rsp_type want);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.kind        <= r.kind;
      req_bus.page_number <= r.page_number;
      req_bus.owner_id    <= r.owner_id;
      req_bus.frame_index <= r.frame_index;
      req_bus.file_id     <= r.file_id;
      req_bus.mmap_flag   <= r.mmap_flag;
      req_bus.zero_fill   <= r.zero_fill;
      do @(posedge clock); while (!(req_bus.valid === 1'b1 && req_bus.ready === 1'b1));
      req_count++;
      predict_frame_rsp(r);
      if (typed) begin
         // hand-written expectation replaces the predicted single result
         void'(pending_rsp.pop_back());
         pending_rsp.push_back(want);
      end
   endtask

   task automatic wait_idle();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic [5:0] v);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= CSR_FRAME_LIMIT;
      csr_pwdata  <= {26'd0, v};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (!wr && csr_prdata[LIMIT_W-1:0] !== v)
         report($sformatf("frame_limit read %0d, wrote %0d", csr_prdata[LIMIT_W-1:0], v));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_frame_limit(input logic [5:0] v);
      // drop the request so the idle block does not take it again
      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait_idle();
      csr_access(1'b1, v);
      frame_limit = v;
      csr_access(1'b0, v);
   endtask

   function automatic req_item_type random_request();
      req_item_type r;
      int w, lim;
      w = $urandom_range(0, 99);
      r.kind = (w < 38) ? KIND_ALLOC : (w < 56) ? KIND_ACCESS : (w < 64) ? KIND_FREE :
               (w < 76) ? KIND_LOOKUP : (w < 84) ? KIND_UNMAP : (w < 95) ? KIND_REMOVE :
               KIND_W'($urandom_range(6, 7));
      r.page_number = PAGE_W'($urandom);
      // small owner and file pools so the walks find matches
      r.owner_id = ($urandom_range(0, 3) == 0) ? OWNER_W'($urandom_range(0, 255))
                                               : OWNER_W'($urandom_range(0, 3));
      r.file_id  = ($urandom_range(0, 3) == 0) ? FILE_W'($urandom_range(0, 255))
                                               : FILE_W'($urandom_range(0, 3));
      lim = (frame_limit > FRAMES) ? FRAMES : frame_limit;
      if (lim > 0 && $urandom_range(0, 1))
         r.frame_index = SLOT_W'($urandom_range(0, lim - 1));
      else
         r.frame_index = SLOT_W'($urandom_range(0, FRAMES - 1));
      r.mmap_flag = 1'($urandom_range(0, 1));
      r.zero_fill = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // response side: random stalls, compare each transfer with the oldest expectation
   initial begin
      frame_rsp_type got, e;
      string diff;
      int stall;
      bit burst;
      rsp_bus.ready = 1'b0;
      burst = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) burst = !burst;
         stall = burst ? 0 : $urandom_range(0, 14);
         repeat (stall) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1));
         got = '{rsp_bus.status, rsp_bus.out_frame, rsp_bus.out_page, rsp_bus.out_owner,
                 rsp_bus.swap_out, rsp_bus.write_back, rsp_bus.out_file,
                 rsp_bus.clear_frame, rsp_bus.last};
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            report($sformatf("unexpected result transfer %p", got));
         end else begin
            e = pending_rsp.pop_front();
            diff = "";
            if (got.status !== e.status) diff = {diff, " status"};
            if (got.frame  !== e.frame)  diff = {diff, " out_frame"};
            if (got.page   !== e.page)   diff = {diff, " out_page"};
            if (got.owner  !== e.owner)  diff = {diff, " out_owner"};
            if (got.swap   !== e.swap)   diff = {diff, " swap_out"};
            if (got.wback  !== e.wback)  diff = {diff, " write_back"};
            if (got.file   !== e.file)   diff = {diff, " out_file"};
            if (got.clr    !== e.clr)    diff = {diff, " clear_frame"};
            if (got.last   !== e.last)   diff = {diff, " last"};
            if (diff != "")
               report($sformatf("fields%s: got %p want %p", diff, got, e));
            if (e.status == STAT_EVICT) evict_count++;
            if (e.status == STAT_REMOVED) removed_count++;
         end
      end
   end

   initial begin
      stim_row_type dir_rows[$];
      stim_row_type row;
      frame_rsp_type none;
      int limits[8];
      int p, i;
      bit burst;

      limits = '{32, 4, 63, 1, 17, 0, 2, 32};
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_ALLOC;
      req_bus.page_number = '0;
      req_bus.owner_id = '0;
      req_bus.frame_index = '0;
      req_bus.file_id = '0;
      req_bus.mmap_flag = 1'b0;
      req_bus.zero_fill = 1'b0;
      cycle_count = 0;
      err_count = 0;
      hand = 0;
      frame_limit = LIMIT_RESET;
      foreach (tbl_valid[s]) tbl_valid[s] = 1'b0;
      none = '0;

      // directed table: empty table misses, field extremes, walks, limit 0 and eviction
      dir_rows.push_back('{0, 0, req_of(KIND_LOOKUP, 0, 0, 0, 0, 0, 0), 1,
                           rsp_of(STAT_MISS, 0, 0, 0, 0, 0, 0, 0)});
      dir_rows.push_back('{0, 0, req_of(KIND_ACCESS, '1, '1, 31, '1, 1, 1), 1,
                           rsp_of(STAT_MISS, 31, 0, 0, 0, 0, 0, 0)});
      dir_rows.push_back('{0, 0, req_of(KIND_FREE, 0, 0, 5, 0, 0, 0), 1,
                           rsp_of(STAT_MISS, 5, 0, 0, 0, 0, 0, 0)});
      dir_rows.push_back('{0, 0, req_of(KIND_ALLOC, 0, 0, 0, 0, 0, 0), 1,
                           rsp_of(STAT_ALLOC, 0, 0, 0, 0, 0, 0, 0)});
      dir_rows.push_back('{0, 0, req_of(KIND_ALLOC, '1, '1, 31, '1, 1, 1), 1,
                           rsp_of(STAT_ALLOC, 1, 0, 0, 0, 0, 0, 1)});
      dir_rows.push_back('{0, 0, req_of(KIND_LOOKUP, 0, 0, 1, 0, 0, 0), 1,
                           rsp_of(STAT_HIT, 1, '1, '1, 0, 0, 0, 0)});
      dir_rows.push_back('{0, 0, req_of(KIND_ACCESS, 0, 0, 0, 0, 0, 0), 1,
                           rsp_of(STAT_HIT, 0, 0, 0, 0, 0, 0, 0)});
      dir_rows.push_back('{0, 0, req_of(KIND_UNMAP, 0, 0, 0, '1, 0, 0), 1,
                           rsp_of(STAT_REMOVED, 1, '1, '1, 0, 1, '1, 0)});
      dir_rows.push_back('{0, 0, req_of(KIND_REMOVE, 0, 7, 0, 0, 0, 0), 1,
                           rsp_of(STAT_MISS, 0, 0, 0, 0, 0, 0, 0)});
      dir_rows.push_back('{0, 0, req_of(3'd6, '1, '1, 31, '1, 1, 1), 1,
                           rsp_of(STAT_MISS, 0, 0, 0, 0, 0, 0, 0)});
      dir_rows.push_back('{0, 0, req_of(3'd7, 0, 0, 0, 0, 0, 0), 1,
                           rsp_of(STAT_MISS, 0, 0, 0, 0, 0, 0, 0)});
      dir_rows.push_back('{0, 0, req_of(KIND_FREE, 0, 0, 0, 0, 0, 0), 1,
                           rsp_of(STAT_REMOVED, 0, 0, 0, 0, 0, 0, 0)});
      dir_rows.push_back('{0, 0, req_of(KIND_UNMAP, 0, 0, 0, 3, 0, 0), 1,
                           rsp_of(STAT_MISS, 0, 0, 0, 0, 0, 0, 0)});
      dir_rows.push_back('{1, 0, req_of(0, 0, 0, 0, 0, 0, 0), 0, none});
      dir_rows.push_back('{0, 0, req_of(KIND_ALLOC, 5, 1, 0, 2, 1, 1), 1,
                           rsp_of(STAT_MISS, 0, 0, 0, 0, 0, 0, 0)});
      dir_rows.push_back('{1, 1, req_of(0, 0, 0, 0, 0, 0, 0), 0, none});
      dir_rows.push_back('{0, 0, req_of(KIND_ALLOC, 'h12345, 1, 0, 9, 1, 0), 1,
                           rsp_of(STAT_ALLOC, 0, 0, 0, 0, 0, 0, 0)});
      dir_rows.push_back('{0, 0, req_of(KIND_ACCESS, 0, 0, 0, 0, 0, 0), 0, none});
      dir_rows.push_back('{0, 0, req_of(KIND_ALLOC, 'h00abc, 2, 0, 4, 0, 1), 0, none});
      dir_rows.push_back('{0, 0, req_of(KIND_ALLOC, 'hfedcb, 1, 0, 9, 1, 0), 0, none});
      dir_rows.push_back('{0, 0, req_of(KIND_REMOVE, 0, 1, 0, 0, 0, 0), 0, none});
      dir_rows.push_back('{1, 32, req_of(0, 0, 0, 0, 0, 0, 0), 0, none});
      dir_rows.push_back('{0, 0, req_of(KIND_ALLOC, 'h55555, 3, 0, 9, 1, 0), 0, none});
      dir_rows.push_back('{0, 0, req_of(KIND_ALLOC, 'haaaaa, 3, 0, 9, 1, 1), 0, none});
      dir_rows.push_back('{0, 0, req_of(KIND_UNMAP, 0, 0, 0, 9, 0, 0), 0, none});

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[k]) begin
         row = dir_rows[k];
         if (row.is_cfg) set_frame_limit(row.limit_val);
         else send_request(row.item, $urandom_range(0, 14), row.typed, row.want);
      end

      // random phases, each under its own frame limit
      burst = 0;
      for (p = 0; p < 8; p++) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         set_frame_limit(limits[p][5:0]);
         for (i = 0; i < 36; i++) begin
            if ($urandom_range(0, 19) == 0) burst = !burst;
            send_request(random_request(), burst ? 0 : $urandom_range(0, 14), 0, none);
         end
      end
      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait_idle();

      $display("covered %0d requests and %0d result transfers under 8 frame limits",
               req_count, rsp_count);
      $display("including %0d evictions and %0d removals", evict_count, removed_count);
      if (err_count == 0 && pending_rsp.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d results never seen", err_count, pending_rsp.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
